[hw/rtl/tpcl_pkg.sv]
// Shared types and constants for the threshold promote cache list.
`timescale 1ns / 1ps

package tpcl_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 1;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned OCC_W      = 4;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CAP_W      = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACCESS = 1'b0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 4'd1;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET = 8'd5;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

  // Count limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_NEW = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT
  } tpcl_state_e;

  // Command from the sequencer to the entry list
  typedef struct packed {
    logic write_count;
    logic shift_front;
  } list_cmd_t;

endpackage

[hw/rtl/tpcl_if.sv]
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps

interface tpcl_req_if #(
  parameter int unsigned KEY_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [tpcl_pkg::OP_W-1:0]      op;
  logic [KEY_BITS-1:0]            key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface tpcl_rsp_if #(
  parameter int unsigned KEY_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [tpcl_pkg::POS_W-1:0]      hit_position;
  logic [tpcl_pkg::COUNT_W-1:0]    count_after;
  logic                            promoted;
  logic                            evicted_valid;
  logic [KEY_BITS-1:0]             evicted_key;
  logic [tpcl_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, output hit, output hit_position, output count_after,
                  output promoted, output evicted_valid, output evicted_key,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input hit_position, input count_after,
                  input promoted, input evicted_valid, input evicted_key,
                  input occupancy, output ready);
endinterface

interface tpcl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpcl_pkg::CFG_IDX_W-1:0]    index;
  logic [tpcl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tpcl_entry_list.sv]
// Ordered row of key/count cells with a single read port and shift-to-front.
`timescale 1ns / 1ps

module tpcl_entry_list #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned KEY_BITS    = 16,
  localparam int unsigned IdxW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                           clk_i,
  input  tpcl_pkg::list_cmd_t            cmd_i,
  input  logic [IdxW-1:0]                idx_i,
  input  logic [KEY_BITS-1:0]            key_i,
  input  logic [tpcl_pkg::COUNT_W-1:0]   count_i,
  output logic [KEY_BITS-1:0]            rd_key_o,
  output logic [tpcl_pkg::COUNT_W-1:0]   rd_count_o
);

  logic [KEY_BITS-1:0]           keys_q   [MAX_ENTRIES];
  logic [tpcl_pkg::COUNT_W-1:0]  counts_q [MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (cmd_i.shift_front) begin
          keys_q[0]   <= key_i;
          counts_q[0] <= count_i;
        end else if (cmd_i.write_count && (idx_i == IdxW'(0))) begin
          counts_q[0] <= count_i;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (cmd_i.shift_front) begin
          // cells up to the source position move back by one
          if (IdxW'(i) <= idx_i) begin
            keys_q[i]   <= keys_q[i-1];
            counts_q[i] <= counts_q[i-1];
          end
        end else if (cmd_i.write_count && (idx_i == IdxW'(i))) begin
          counts_q[i] <= count_i;
        end
      end
    end
  end

  assign rd_key_o   = keys_q[idx_i];
  assign rd_count_o = counts_q[idx_i];

endmodule

[hw/rtl/threshold_promote_cache_list_core.sv]
// Top level: sequencer that scans the list one entry per cycle and updates it.
// A clear answers from the scan state, a hit ends the scan at its position, and a miss
// scans every held entry and then inserts the key at the front.
// One request in flight; a new word is taken once the sequencer is back in idle.
// The per-entry scan through the single compare and read port sets the rate.
// Reset empties the list and loads threshold 5 and capacity 4; cell contents stay.
`timescale 1ns / 1ps

module threshold_promote_cache_list_core #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tpcl_req_if.sink   req_i,
  tpcl_rsp_if.source rsp_o,
  tpcl_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > tpcl_pkg::CAP_W) ? CntW : tpcl_pkg::CAP_W;

  tpcl_pkg::tpcl_state_e state_q, state_d;

  logic [tpcl_pkg::OP_W-1:0]   op_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             held_q, held_d;
  logic [tpcl_pkg::THR_W-1:0]  thr_q;
  logic [tpcl_pkg::CAP_W-1:0]  cap_q;

  // response register
  logic                          rsp_valid_q;
  logic                          hit_q, hit_d;
  logic [tpcl_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [tpcl_pkg::COUNT_W-1:0]  cafter_q, cafter_d;
  logic                          prom_q, prom_d;
  logic                          evv_q, evv_d;
  logic [KEY_BITS-1:0]           evk_q, evk_d;
  logic [tpcl_pkg::OCC_W-1:0]    occ_q, occ_d;

  logic                          done;
  logic                          rsp_free;
  logic                          req_fire;
  logic                          scan_end;
  logic                          match;
  logic                          promote;
  logic [tpcl_pkg::COUNT_W-1:0]  count_inc;

  logic [CmpW-1:0]               cap_ext, cap_eff, cap_m1, held_ext;
  logic                          evict;
  logic [CntW-1:0]               keep;

  tpcl_pkg::list_cmd_t           cmd;
  logic [IdxW-1:0]               list_idx;
  logic [tpcl_pkg::COUNT_W-1:0]  list_count;
  logic [KEY_BITS-1:0]           rd_key;
  logic [tpcl_pkg::COUNT_W-1:0]  rd_count;

  tpcl_entry_list #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_list (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .idx_i      (list_idx),
    .key_i      (key_q),
    .count_i    (list_count),
    .rd_key_o   (rd_key),
    .rd_count_o (rd_count)
  );

  assign req_i.ready = (state_q == tpcl_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  // Shared compare and increment unit
  assign scan_end  = (cnt_q == held_q);
  assign match     = (rd_key == key_q);
  assign count_inc = (rd_count == tpcl_pkg::COUNT_MAX) ? rd_count
                                                       : rd_count + tpcl_pkg::COUNT_W'(1);
  assign promote   = (count_inc > thr_q) && (cnt_q != CntW'(0));
  assign list_idx  = cnt_q[IdxW-1:0];

  // Capacity clamp and how much of the list survives an insert
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == CmpW'(0)) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CmpW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    cap_m1   = cap_eff - CmpW'(1);
    held_ext = CmpW'(held_q);
    evict    = (held_ext > cap_m1);
    keep     = evict ? CntW'(cap_m1) : held_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpcl_pkg::ST_IDLE: begin
        if (req_fire) state_d = tpcl_pkg::ST_SCAN;
      end
      tpcl_pkg::ST_SCAN: begin
        if (op_q == tpcl_pkg::OP_CLEAR) begin
          if (rsp_free) state_d = tpcl_pkg::ST_IDLE;
        end else if (scan_end) begin
          state_d = tpcl_pkg::ST_INSERT;
        end else if (match) begin
          if (rsp_free) state_d = tpcl_pkg::ST_IDLE;
        end
      end
      tpcl_pkg::ST_INSERT: begin
        if (rsp_free) state_d = tpcl_pkg::ST_IDLE;
      end
      default: state_d = tpcl_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and response values
  always_comb begin
    done       = 1'b0;
    cmd        = '0;
    list_count = count_inc;
    cnt_d      = cnt_q;
    held_d     = held_q;
    hit_d      = 1'b0;
    pos_d      = '0;
    cafter_d   = '0;
    prom_d     = 1'b0;
    evv_d      = 1'b0;
    evk_d      = '0;
    occ_d      = tpcl_pkg::OCC_W'(held_q);
    case (state_q)
      tpcl_pkg::ST_IDLE: begin
        if (req_fire) cnt_d = '0;
      end
      tpcl_pkg::ST_SCAN: begin
        if (op_q == tpcl_pkg::OP_CLEAR) begin
          if (rsp_free) begin
            done   = 1'b1;
            held_d = '0;
            occ_d  = '0;
          end
        end else if (scan_end) begin
          // miss: point at the survivor boundary for the insert
          cnt_d = keep;
        end else if (match) begin
          if (rsp_free) begin
            done             = 1'b1;
            cmd.shift_front  = promote;
            cmd.write_count  = !promote;
            hit_d            = 1'b1;
            pos_d            = tpcl_pkg::POS_W'(cnt_q);
            cafter_d         = count_inc;
            prom_d           = promote;
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      tpcl_pkg::ST_INSERT: begin
        if (rsp_free) begin
          done            = 1'b1;
          cmd.shift_front = 1'b1;
          list_count      = tpcl_pkg::COUNT_NEW;
          held_d          = keep + CntW'(1);
          cafter_d        = tpcl_pkg::COUNT_NEW;
          evv_d           = evict;
          evk_d           = evict ? rd_key : '0;
          occ_d           = tpcl_pkg::OCC_W'(keep + CntW'(1));
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpcl_pkg::ST_IDLE;
      held_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      thr_q       <= tpcl_pkg::THR_RESET;
      cap_q       <= tpcl_pkg::CAP_RESET;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == tpcl_pkg::CFG_THRESHOLD) begin
          thr_q <= cfg_i.data;
        end else if (cfg_i.index == tpcl_pkg::CFG_CAPACITY) begin
          cap_q <= cfg_i.data[tpcl_pkg::CAP_W-1:0];
        end
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
    end
    if (done) begin
      hit_q    <= hit_d;
      pos_q    <= pos_d;
      cafter_q <= cafter_d;
      prom_q   <= prom_d;
      evv_q    <= evv_d;
      evk_q    <= evk_d;
      occ_q    <= occ_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = hit_q;
  assign rsp_o.hit_position  = pos_q;
  assign rsp_o.count_after   = cafter_q;
  assign rsp_o.promoted      = prom_q;
  assign rsp_o.evicted_valid = evv_q;
  assign rsp_o.evicted_key   = evk_q;
  assign rsp_o.occupancy     = occ_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(MAX_ENTRIES))
    else $error("occupancy above list depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpcl_pkg::ST_SCAN) |-> (cnt_q <= held_q))
    else $error("scan index ran past the held entries");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == tpcl_pkg::ST_SCAN && cnt_q == '0))
    else $error("accepted word did not start a scan from the front");

  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpcl_pkg::ST_INSERT && rsp_free) |=> (rsp_valid_q && held_q != '0))
    else $error("insert left the list empty or gave no response");

  a_hold_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !done)
    else $error("response overwritten while still pending");

endmodule
